### sv/cspbq_pkg.sv
// ----------------------------------------------------------------------------
// cspbq_pkg
// Shared types and constants for the capsule set point and box query core.
// ----------------------------------------------------------------------------
package cspbq_pkg;

    localparam int COORD_W    = 24;
    localparam int RAD_W      = 23;
    localparam int CODE_W     = 16;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    // wide exact arithmetic: product and operand widths of the shared multiplier
    localparam int WIDE_W = 168;
    localparam int MA_W   = 112;
    localparam int MB_W   = 84;
    localparam int NDIG   = MB_W / 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POINT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAIN = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WOOD_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WOOD  = 2'd3;

    typedef enum logic [2:0] {
        K_CLEAR, K_LOAD, K_POINT, K_TOUCH, K_CONTAIN, K_NOP
    } kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W+2:0] ext_t;
    typedef logic        [RAD_W-1:0]   rad_t;
    typedef logic        [CODE_W-1:0]  code_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    typedef struct packed {
        kind_t  kind;
        coord_t fx;
        coord_t fy;
        coord_t fz;
        coord_t sx;
        coord_t sy;
        coord_t sz;
        rad_t   radius;
        logic   leaf;
    } item_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        rad_t   radius;
        logic   leaf;
    } prim_t;

    typedef struct packed {
        code_t wood_code;
        code_t leaf_code;
        code_t air_code;
        rad_t  min_wood_radius;
    } cfg_t;

endpackage

### sv/cspbq_front.sv
// ----------------------------------------------------------------------------
// cspbq_front
// Accepts input beats, decodes the command and prepares load radius.
// ----------------------------------------------------------------------------
module cspbq_front import cspbq_pkg::*; (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  coord_t             s_first_x,
    input  coord_t             s_first_y,
    input  coord_t             s_first_z,
    input  coord_t             s_second_x,
    input  coord_t             s_second_y,
    input  coord_t             s_second_z,
    input  rad_t               s_prim_radius,
    input  logic               s_is_leaf,
    input  cfg_t               cfg,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // command decode and wood radius floor
    always_comb begin
        unique case (s_cmd)
            CMD_CLEAR:   q_item.kind = K_CLEAR;
            CMD_LOAD:    q_item.kind = K_LOAD;
            CMD_POINT:   q_item.kind = K_POINT;
            CMD_TOUCH:   q_item.kind = K_TOUCH;
            CMD_CONTAIN: q_item.kind = K_CONTAIN;
            default:     q_item.kind = K_NOP;
        endcase
        q_item.fx   = s_first_x;
        q_item.fy   = s_first_y;
        q_item.fz   = s_first_z;
        q_item.sx   = s_second_x;
        q_item.sy   = s_second_y;
        q_item.sz   = s_second_z;
        q_item.leaf = s_is_leaf;
        if (!s_is_leaf && (s_prim_radius < cfg.min_wood_radius)) begin
            q_item.radius = cfg.min_wood_radius;
        end else begin
            q_item.radius = s_prim_radius;
        end
    end

endmodule

### sv/cspbq_queue.sv
// ----------------------------------------------------------------------------
// cspbq_queue
// Two-entry queue between the front and the engine.
// ----------------------------------------------------------------------------
module cspbq_queue import cspbq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t      entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;

    assign full       = (level_reg == 2'd2);
    assign head_valid = (level_reg != 2'd0);
    assign head_item  = entries_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 2'd1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/cspbq_mul.sv
// ----------------------------------------------------------------------------
// cspbq_mul
// Signed multiplier, four bits of the second operand per cycle.
// ----------------------------------------------------------------------------
module cspbq_mul import cspbq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    output logic                   done,
    output wide_t                  p
);

    localparam int CNT_W = $clog2(NDIG);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MA_W-1:0]   amag_reg;
    logic [MB_W-1:0]   bmag_reg;
    logic              neg_reg;
    logic [WIDE_W-1:0] acc_reg;
    wide_t             p_reg;
    logic [MA_W+3:0]   part;
    logic [WIDE_W-1:0] acc_next;

    assign done = done_reg;
    assign p    = p_reg;

    // one digit partial product and shift-accumulate
    always_comb begin
        part     = {4'b0, amag_reg} * {{MA_W{1'b0}}, bmag_reg[MB_W-1 -: 4]};
        acc_next = {acc_reg[WIDE_W-5:0], 4'b0} + WIDE_W'(part);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            amag_reg <= a[MA_W-1] ? $unsigned(-a) : $unsigned(a);
            bmag_reg <= b[MB_W-1] ? $unsigned(-b) : $unsigned(b);
            neg_reg  <= a[MA_W-1] ^ b[MB_W-1];
            acc_reg  <= '0;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            bmag_reg <= {bmag_reg[MB_W-5:0], 4'b0};
            if (cnt_reg == CNT_W'(NDIG - 1)) begin
                p_reg <= neg_reg ? -$signed(acc_next) : $signed(acc_next);
            end
        end
    end

endmodule

### sv/cspbq_engine.sv
// ----------------------------------------------------------------------------
// cspbq_engine
// Back end: primitive table, scan sequencer, exact geometry and result beat.
// ----------------------------------------------------------------------------
module cspbq_engine import cspbq_pkg::*; #(
    parameter  int MAX_PRIMS = 256,
    localparam int IDX_W     = (MAX_PRIMS > 1) ? $clog2(MAX_PRIMS) : 1,
    localparam int CNT_W     = $clog2(MAX_PRIMS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output code_t            m_material,
    output logic             m_hit,
    output logic             m_status,
    output logic [CNT_W-1:0] count
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_CALC, ST_MUL, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        U_DEN, U_NUM, U_AP, U_RR, U_PDEC, U_BP, U_CA, U_CB, U_CC, U_RD,
        U_BDEC, U_S1, U_S2, U_LQ, U_HQ, U_DF, U_QQ, U_RQ, U_FIN
    } uop_t;

    state_t           state_reg;
    uop_t             uop_reg;
    logic [1:0]       k_reg;
    logic [2:0]       corner_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    item_t            item_reg;
    logic             wood_seen_reg;
    logic             leaf_seen_reg;
    logic             hit_reg;
    logic             status_reg;
    logic             m_valid_reg;
    code_t            m_material_reg;
    logic             m_hit_reg;
    logic             m_status_reg;
    wide_t            denom_reg, num_reg, acc_reg, r2_reg, tmp_reg, c_reg;
    wide_t            q_reg, n_reg, s_reg, lq_reg, hq_reg;

    prim_t            mem [MAX_PRIMS];
    prim_t            prim_q;
    logic             mem_we;

    ext_t  a_e [3], b_e [3], lo_e [3], hi_e [3], p_e [3];
    ext_t  d_e [3], ap_e [3], pb_e [3], tm_e [3];
    ext_t  mid_e, ak, dk, apk, pbk, tmk, lok, hik, ap_u, ap_v, d_u, d_v;
    logic [1:0] ku, kv;
    wide_t clamp_w, diff_w, den2_w, ma_w, mb_w;
    logic  is_mul, mul_start, mul_done, fin_ok, full, last_prim;
    wide_t mul_p;

    function automatic ext_t pick3(input logic [1:0] sel, input ext_t x, ext_t y, ext_t z);
        ext_t r;
        unique case (sel)
            2'd0:    r = x;
            2'd1:    r = y;
            default: r = z;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nxt(input logic [1:0] sel);
        logic [1:0] r;
        unique case (sel)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    assign m_valid    = m_valid_reg;
    assign m_material = m_material_reg;
    assign m_hit      = m_hit_reg;
    assign m_status   = m_status_reg;
    assign count      = count_reg;

    assign full      = (count_reg == CNT_W'(MAX_PRIMS));
    assign last_prim = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign mem_we    = q_pop && (q_item.kind == K_LOAD) && !full;

    // primitive table, registered read at the scan index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[IDX_W-1:0]] <= '{ax: q_item.fx, ay: q_item.fy, az: q_item.fz,
                                           bx: q_item.sx, by: q_item.sy, bz: q_item.sz,
                                           radius: q_item.radius, leaf: q_item.leaf};
        end
        prim_q <= mem[idx_reg];
    end

    // per-axis small terms
    always_comb begin
        a_e[0]  = ext_t'(prim_q.ax);
        a_e[1]  = ext_t'(prim_q.ay);
        a_e[2]  = ext_t'(prim_q.az);
        b_e[0]  = ext_t'(prim_q.bx);
        b_e[1]  = ext_t'(prim_q.by);
        b_e[2]  = ext_t'(prim_q.bz);
        lo_e[0] = ext_t'(item_reg.fx);
        lo_e[1] = ext_t'(item_reg.fy);
        lo_e[2] = ext_t'(item_reg.fz);
        hi_e[0] = ext_t'(item_reg.sx);
        hi_e[1] = ext_t'(item_reg.sy);
        hi_e[2] = ext_t'(item_reg.sz);
        for (int i = 0; i < 3; i++) begin
            p_e[i]  = corner_reg[i] ? hi_e[i] : lo_e[i];
            d_e[i]  = b_e[i] - a_e[i];
            ap_e[i] = p_e[i] - a_e[i];
            pb_e[i] = p_e[i] - b_e[i];
            // doubled midpoint clamped into the doubled box
            mid_e   = a_e[i] + b_e[i];
            if (mid_e < (lo_e[i] + lo_e[i])) begin
                mid_e = lo_e[i] + lo_e[i];
            end
            if (mid_e > (hi_e[i] + hi_e[i])) begin
                mid_e = hi_e[i] + hi_e[i];
            end
            tm_e[i] = mid_e - (a_e[i] + a_e[i]);
        end
    end

    // axis selection for the current step
    always_comb begin
        ku   = nxt(k_reg);
        kv   = nxt(ku);
        ak   = pick3(k_reg, a_e[0], a_e[1], a_e[2]);
        dk   = pick3(k_reg, d_e[0], d_e[1], d_e[2]);
        apk  = pick3(k_reg, ap_e[0], ap_e[1], ap_e[2]);
        pbk  = pick3(k_reg, pb_e[0], pb_e[1], pb_e[2]);
        tmk  = pick3(k_reg, tm_e[0], tm_e[1], tm_e[2]);
        lok  = pick3(k_reg, lo_e[0], lo_e[1], lo_e[2]);
        hik  = pick3(k_reg, hi_e[0], hi_e[1], hi_e[2]);
        ap_u = pick3(ku, ap_e[0], ap_e[1], ap_e[2]);
        ap_v = pick3(kv, ap_e[0], ap_e[1], ap_e[2]);
        d_u  = pick3(ku, d_e[0], d_e[1], d_e[2]);
        d_v  = pick3(kv, d_e[0], d_e[1], d_e[2]);
        // scaled box clamp of the closest segment point
        clamp_w = (s_reg < lq_reg) ? lq_reg : s_reg;
        clamp_w = (clamp_w > hq_reg) ? hq_reg : clamp_w;
        diff_w  = clamp_w - s_reg;
        den2_w  = denom_reg + denom_reg;
        fin_ok  = (acc_reg <= tmp_reg);
    end

    // multiplier operand select
    always_comb begin
        is_mul = 1'b1;
        ma_w   = '0;
        mb_w   = '0;
        unique case (uop_reg)
            U_DEN: begin ma_w = WIDE_W'(dk); mb_w = WIDE_W'(dk); end
            U_NUM: begin
                ma_w = (item_reg.kind == K_TOUCH) ? WIDE_W'(tmk) : WIDE_W'(apk);
                mb_w = WIDE_W'(dk);
            end
            U_AP:  begin ma_w = WIDE_W'(apk); mb_w = WIDE_W'(apk); end
            U_RR:  begin
                ma_w = $signed({{(WIDE_W-RAD_W){1'b0}}, prim_q.radius});
                mb_w = ma_w;
            end
            U_BP:  begin ma_w = WIDE_W'(pbk); mb_w = WIDE_W'(pbk); end
            U_CA:  begin ma_w = WIDE_W'(ap_u); mb_w = WIDE_W'(d_v); end
            U_CB:  begin ma_w = WIDE_W'(ap_v); mb_w = WIDE_W'(d_u); end
            U_CC:  begin ma_w = c_reg; mb_w = c_reg; end
            U_RD:  begin ma_w = denom_reg; mb_w = r2_reg; end
            U_S1:  begin ma_w = q_reg; mb_w = WIDE_W'(ak); end
            U_S2:  begin ma_w = n_reg; mb_w = WIDE_W'(dk); end
            U_LQ:  begin ma_w = q_reg; mb_w = WIDE_W'(lok); end
            U_HQ:  begin ma_w = q_reg; mb_w = WIDE_W'(hik); end
            U_DF:  begin ma_w = diff_w; mb_w = diff_w; end
            U_QQ:  begin ma_w = q_reg; mb_w = q_reg; end
            U_RQ:  begin ma_w = tmp_reg; mb_w = r2_reg; end
            default: is_mul = 1'b0;
        endcase
    end

    assign mul_start = (state_reg == ST_CALC) && is_mul;

    cspbq_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       ($signed(ma_w[MA_W-1:0])),
        .b       ($signed(mb_w[MB_W-1:0])),
        .done    (mul_done),
        .p       (mul_p)
    );

    // scan sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg      <= q_item;
                        corner_reg    <= 3'd0;
                        wood_seen_reg <= 1'b0;
                        leaf_seen_reg <= 1'b0;
                        hit_reg       <= 1'b0;
                        status_reg    <= 1'b0;
                        idx_reg       <= '0;
                        state_reg     <= ST_OUT;
                        unique case (q_item.kind)
                            K_CLEAR: count_reg <= '0;
                            K_LOAD: begin
                                if (full) begin
                                    status_reg <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            K_POINT, K_TOUCH, K_CONTAIN: begin
                                if (count_reg != '0) begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_CALC;
                    uop_reg   <= U_DEN;
                    k_reg     <= 2'd0;
                    denom_reg <= '0;
                    num_reg   <= '0;
                    acc_reg   <= '0;
                end
                ST_CALC: begin
                    if (is_mul) begin
                        state_reg <= ST_MUL;
                    end else begin
                        unique case (uop_reg)
                            U_PDEC: begin
                                k_reg <= 2'd0;
                                if ((denom_reg == '0) || (num_reg <= 0)) begin
                                    tmp_reg <= r2_reg;
                                    uop_reg <= U_FIN;
                                end else if (num_reg >= denom_reg) begin
                                    acc_reg <= '0;
                                    tmp_reg <= r2_reg;
                                    uop_reg <= U_BP;
                                end else begin
                                    acc_reg <= '0;
                                    uop_reg <= U_CA;
                                end
                            end
                            U_BDEC: begin
                                k_reg   <= 2'd0;
                                acc_reg <= '0;
                                uop_reg <= U_S1;
                                if ((den2_w == '0) || (num_reg <= 0)) begin
                                    q_reg <= WIDE_W'(1);
                                    n_reg <= '0;
                                end else if (num_reg >= den2_w) begin
                                    q_reg <= WIDE_W'(1);
                                    n_reg <= WIDE_W'(1);
                                end else begin
                                    q_reg <= den2_w;
                                    n_reg <= num_reg;
                                end
                            end
                            default: begin
                                // outcome of one primitive test
                                priority if (item_reg.kind == K_POINT && fin_ok
                                             && !prim_q.leaf) begin
                                    wood_seen_reg <= 1'b1;
                                    state_reg     <= ST_OUT;
                                end else if (item_reg.kind == K_TOUCH && fin_ok) begin
                                    hit_reg   <= 1'b1;
                                    state_reg <= ST_OUT;
                                end else if (item_reg.kind == K_CONTAIN && fin_ok
                                             && corner_reg == 3'd7) begin
                                    hit_reg   <= 1'b1;
                                    state_reg <= ST_OUT;
                                end else if (item_reg.kind == K_CONTAIN && fin_ok) begin
                                    corner_reg <= corner_reg + 3'd1;
                                    uop_reg    <= U_DEN;
                                    k_reg      <= 2'd0;
                                    denom_reg  <= '0;
                                    num_reg    <= '0;
                                    acc_reg    <= '0;
                                end else begin
                                    if (fin_ok) begin
                                        leaf_seen_reg <= 1'b1;
                                    end
                                    corner_reg <= 3'd0;
                                    if (last_prim) begin
                                        state_reg <= ST_OUT;
                                    end else begin
                                        idx_reg   <= idx_reg + IDX_W'(1);
                                        state_reg <= ST_FETCH;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        state_reg <= ST_CALC;
                        // axis index holds across the steps within one axis
                        if (uop_reg != U_CA && uop_reg != U_CB && uop_reg != U_S1
                            && uop_reg != U_S2 && uop_reg != U_LQ && uop_reg != U_HQ) begin
                            k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        end
                        unique case (uop_reg)
                            U_DEN: begin
                                denom_reg <= denom_reg + mul_p;
                                if (k_reg == 2'd2) uop_reg <= U_NUM;
                            end
                            U_NUM: begin
                                num_reg <= num_reg + mul_p;
                                if (k_reg == 2'd2) begin
                                    uop_reg <= (item_reg.kind == K_TOUCH) ? U_RR : U_AP;
                                end
                            end
                            U_AP: begin
                                acc_reg <= acc_reg + mul_p;
                                if (k_reg == 2'd2) uop_reg <= U_RR;
                            end
                            U_RR: begin
                                r2_reg  <= mul_p;
                                uop_reg <= (item_reg.kind == K_TOUCH) ? U_BDEC : U_PDEC;
                            end
                            U_BP: begin
                                acc_reg <= acc_reg + mul_p;
                                if (k_reg == 2'd2) uop_reg <= U_FIN;
                            end
                            U_CA: begin
                                c_reg   <= mul_p;
                                uop_reg <= U_CB;
                            end
                            U_CB: begin
                                c_reg   <= c_reg - mul_p;
                                uop_reg <= U_CC;
                            end
                            U_CC: begin
                                acc_reg <= acc_reg + mul_p;
                                uop_reg <= (k_reg == 2'd2) ? U_RD : U_CA;
                            end
                            U_RD: begin
                                tmp_reg <= mul_p;
                                uop_reg <= U_FIN;
                            end
                            U_S1: begin
                                s_reg   <= mul_p;
                                uop_reg <= U_S2;
                            end
                            U_S2: begin
                                s_reg   <= s_reg + mul_p;
                                uop_reg <= U_LQ;
                            end
                            U_LQ: begin
                                lq_reg  <= mul_p;
                                uop_reg <= U_HQ;
                            end
                            U_HQ: begin
                                hq_reg  <= mul_p;
                                uop_reg <= U_DF;
                            end
                            U_DF: begin
                                acc_reg <= acc_reg + mul_p;
                                uop_reg <= (k_reg == 2'd2) ? U_QQ : U_S1;
                            end
                            U_QQ: begin
                                tmp_reg <= mul_p;
                                uop_reg <= U_RQ;
                            end
                            default: begin
                                tmp_reg <= mul_p;
                                uop_reg <= U_FIN;
                            end
                        endcase
                    end
                end
                default: begin
                    // result beat, waits for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        if (item_reg.kind == K_POINT) begin
                            m_hit_reg <= wood_seen_reg || leaf_seen_reg;
                            if (wood_seen_reg) begin
                                m_material_reg <= cfg.wood_code;
                            end else if (leaf_seen_reg) begin
                                m_material_reg <= cfg.leaf_code;
                            end else begin
                                m_material_reg <= cfg.air_code;
                            end
                        end else begin
                            m_hit_reg      <= hit_reg;
                            m_material_reg <= cfg.air_code;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

### sv/capsule_set_point_box_query_core.sv
// ----------------------------------------------------------------------------
// capsule_set_point_box_query_core
// Capsule and ball table with point classify and box overlap/containment.
// ----------------------------------------------------------------------------
// clear, load and unknown commands go from the queue straight to the result beat;
// queries fetch each stored primitive in turn and run its test on the multiplier:
// a point test takes 10, 13 or 20 multiplies, a box overlap test 24, box containment
// up to 8 point tests per primitive, each extra corner without a new fetch; the shared
// 4-bit-per-cycle multiplier does every multiply; one item is worked at a time, two more may queue
// reset: table empty (count zero), config registers at defaults, no clearing pass
module capsule_set_point_box_query_core import cspbq_pkg::*; #(
    parameter int MAX_PRIMS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  coord_t                s_first_x,
    input  coord_t                s_first_y,
    input  coord_t                s_first_z,
    input  coord_t                s_second_x,
    input  coord_t                s_second_y,
    input  coord_t                s_second_z,
    input  rad_t                  s_prim_radius,
    input  logic                  s_is_leaf,
    output logic                  m_valid,
    input  logic                  m_ready,
    output code_t                 m_material,
    output logic                  m_hit,
    output logic                  m_status
);

    localparam int CNT_W = $clog2(MAX_PRIMS + 1);

    cfg_t             cfg_reg;
    logic             q_full, q_push, q_pop, q_valid;
    item_t            push_item, head_item;
    logic [CNT_W-1:0] eng_count;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wood_code       <= CODE_W'(1);
            cfg_reg.leaf_code       <= CODE_W'(2);
            cfg_reg.air_code        <= '0;
            cfg_reg.min_wood_radius <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WOOD_CODE: cfg_reg.wood_code       <= cfg_wdata[CODE_W-1:0];
                CFG_LEAF_CODE: cfg_reg.leaf_code       <= cfg_wdata[CODE_W-1:0];
                CFG_AIR_CODE:  cfg_reg.air_code        <= cfg_wdata[CODE_W-1:0];
                CFG_MIN_WOOD:  cfg_reg.min_wood_radius <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    cspbq_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_first_x     (s_first_x),
        .s_first_y     (s_first_y),
        .s_first_z     (s_first_z),
        .s_second_x    (s_second_x),
        .s_second_y    (s_second_y),
        .s_second_z    (s_second_z),
        .s_prim_radius (s_prim_radius),
        .s_is_leaf     (s_is_leaf),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    cspbq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    cspbq_engine #(.MAX_PRIMS(MAX_PRIMS)) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_material (m_material),
        .m_hit      (m_hit),
        .m_status   (m_status),
        .count      (eng_count)
    );

    // a dropped load never reports a hit
    a_drop_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_hit)
        else $error("dropped load beat carries hit");

    // a dropped load reports the air code
    a_drop_air: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_material == cfg_reg.air_code)
        else $error("dropped load beat has wrong material");

    // table fill never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_count <= CNT_W'(MAX_PRIMS))
        else $error("table count above capacity");

    // reset empties the table
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> eng_count == '0)
        else $error("table not empty after reset");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the capsule set point and box query core. A
// scoreboard class keeps its own primitive table and register copy, predicts
// the material, hit and status of every accepted beat with exact wide integer
// geometry, and checks result beats in order. Directed beats cover the empty
// table, each command, end caps, balls, inverted boxes, unknown commands and a
// full table; random phases under several register settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import cspbq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam rad_t RAD_MAX = {RAD_W{1'b1}};

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        coord_t           f[3];
        coord_t           s[3];
        rad_t             radius;
        logic             leaf;
    } beat_t;

    typedef struct {
        code_t material;
        logic  hit;
        logic  status;
    } answer_t;

    // scoreboard: table copy, register copy and pending answers
    class material_board;
        prim_t       prims[TABLE_DEPTH];
        int unsigned count;
        code_t       wood_code, leaf_code, air_code;
        rad_t        min_wood;
        answer_t     pending_q[$];
        int          errors, checked;
        int          n_wood, n_leaf, n_air, n_touch_hit, n_contain_hit, n_dropped;

        function new();
            count = 0;
            wood_code = 1;
            leaf_code = 2;
            air_code = 0;
            min_wood = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WOOD_CODE: wood_code = val[CODE_W-1:0];
                CFG_LEAF_CODE: leaf_code = val[CODE_W-1:0];
                CFG_AIR_CODE:  air_code = val[CODE_W-1:0];
                CFG_MIN_WOOD:  min_wood = val[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        function void ends_of(prim_t p, output big_t a[3], output big_t b[3]);
            a[0] = big_t'($signed(p.ax)); a[1] = big_t'($signed(p.ay));
            a[2] = big_t'($signed(p.az));
            b[0] = big_t'($signed(p.bx)); b[1] = big_t'($signed(p.by));
            b[2] = big_t'($signed(p.bz));
        endfunction

        // squared distance to segment against squared radius, no division
        function bit holds_point(big_t pt[3], prim_t p);
            big_t a[3], b[3], d[3], ap[3];
            big_t r2, denom, num, ap2, bp2, cr, c;
            int u, v;
            ends_of(p, a, b);
            r2 = big_t'(p.radius) * big_t'(p.radius);
            denom = 0; num = 0; ap2 = 0; bp2 = 0; cr = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = b[k] - a[k];
                ap[k] = pt[k] - a[k];
                denom += d[k] * d[k];
                num += ap[k] * d[k];
                ap2 += ap[k] * ap[k];
                bp2 += (pt[k] - b[k]) * (pt[k] - b[k]);
            end
            if (denom == 0 || num <= 0) return ap2 <= r2;
            if (num >= denom) return bp2 <= r2;
            for (int k = 0; k < 3; k++) begin
                u = (k + 1) % 3;
                v = (k + 2) % 3;
                c = ap[u] * d[v] - ap[v] * d[u];
                cr += c * c;
            end
            return cr <= r2 * denom;
        endfunction

        // clamped midpoint, closest segment point, nearest box point
        function bit touches_box(big_t lo[3], big_t hi[3], prim_t p);
            big_t a[3], b[3], d[3];
            big_t r2, denom, num, q, n, acc, mid2, sp, lq, hq, cl;
            ends_of(p, a, b);
            r2 = big_t'(p.radius) * big_t'(p.radius);
            denom = 0; num = 0; acc = 0;
            for (int k = 0; k < 3; k++) begin
                mid2 = a[k] + b[k];
                if (mid2 < 2 * lo[k]) mid2 = 2 * lo[k];
                if (mid2 > 2 * hi[k]) mid2 = 2 * hi[k];
                d[k] = b[k] - a[k];
                denom += d[k] * d[k];
                num += (mid2 - 2 * a[k]) * d[k];
            end
            denom = denom + denom;
            if (denom == 0 || num <= 0) begin
                q = 1; n = 0;
            end else if (num >= denom) begin
                q = 1; n = 1;
            end else begin
                q = denom; n = num;
            end
            for (int k = 0; k < 3; k++) begin
                sp = q * a[k] + n * d[k];
                lq = q * lo[k];
                hq = q * hi[k];
                cl = sp;
                if (cl < lq) cl = lq;
                if (cl > hq) cl = hq;
                acc += (cl - sp) * (cl - sp);
            end
            return acc <= r2 * q * q;
        endfunction

        function bit holds_box(big_t lo[3], big_t hi[3], prim_t p);
            big_t c[3];
            for (int corner = 0; corner < 8; corner++) begin
                for (int k = 0; k < 3; k++) c[k] = corner[k] ? hi[k] : lo[k];
                if (!holds_point(c, p)) return 0;
            end
            return 1;
        endfunction

        function void note_input(beat_t it);
            answer_t ans;
            big_t f[3], s[3];
            bit wood_seen, leaf_seen;
            rad_t r;
            ans.material = air_code;
            ans.hit = 0;
            ans.status = 0;
            for (int k = 0; k < 3; k++) begin
                f[k] = big_t'($signed(it.f[k]));
                s[k] = big_t'($signed(it.s[k]));
            end
            case (it.cmd)
                CMD_CLEAR: count = 0;
                CMD_LOAD: begin
                    if (count >= TABLE_DEPTH) begin
                        ans.status = 1;
                        n_dropped++;
                    end else begin
                        r = it.radius;
                        if (!it.leaf && r < min_wood) r = min_wood;
                        prims[count] = '{it.f[0], it.f[1], it.f[2],
                                         it.s[0], it.s[1], it.s[2], r, it.leaf};
                        count++;
                    end
                end
                CMD_POINT: begin
                    wood_seen = 0;
                    leaf_seen = 0;
                    for (int i = 0; i < count && !wood_seen; i++)
                        if (holds_point(f, prims[i])) begin
                            if (prims[i].leaf) leaf_seen = 1;
                            else wood_seen = 1;
                        end
                    ans.material = wood_seen ? wood_code : (leaf_seen ? leaf_code : air_code);
                    ans.hit = wood_seen || leaf_seen;
                    if (wood_seen) n_wood++;
                    else if (leaf_seen) n_leaf++;
                    else n_air++;
                end
                CMD_TOUCH: begin
                    for (int i = 0; i < count && !ans.hit; i++)
                        if (touches_box(f, s, prims[i])) ans.hit = 1;
                    n_touch_hit += ans.hit;
                end
                CMD_CONTAIN: begin
                    for (int i = 0; i < count && !ans.hit; i++)
                        if (holds_box(f, s, prims[i])) ans.hit = 1;
                    n_contain_hit += ans.hit;
                end
                default: ;
            endcase
            pending_q.insert(pending_q.size(), ans);
        endfunction

        function void check_result(code_t material, logic hit, logic status);
            answer_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: material %h hit %b status %b",
                         $time, material, hit, status);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (material !== want.material) begin
                $display("%0t: material expected %h actual %h", $time, want.material, material);
                errors++;
            end
            if (hit !== want.hit) begin
                $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %b actual %b", $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    coord_t                s_first_x, s_first_y, s_first_z;
    coord_t                s_second_x, s_second_y, s_second_z;
    rad_t                  s_prim_radius;
    logic                  s_is_leaf;
    logic                  m_valid;
    logic                  m_ready;
    code_t                 m_material;
    logic                  m_hit;
    logic                  m_status;

    material_board board;
    int  hold_left = 0;
    int  burst_left = 0;
    bit  bursty = 1;
    int  n_sent = 0;

    capsule_set_point_box_query_core #(.MAX_PRIMS(TABLE_DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_first_x(s_first_x), .s_first_y(s_first_y), .s_first_z(s_first_z),
        .s_second_x(s_second_x), .s_second_y(s_second_y), .s_second_z(s_second_z),
        .s_prim_radius(s_prim_radius), .s_is_leaf(s_is_leaf),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_material(m_material), .m_hit(m_hit), .m_status(m_status)
    );

    // clock
    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // result side stall pattern, with a long hold-off on request
    initial begin
        int tick;
        int mode;
        tick = 0;
        mode = 0;
        m_ready <= 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (tick % 300 == 0) mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                m_ready <= 0;
                hold_left--;
            end else begin
                case (mode)
                    0: m_ready <= 1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= (tick % 7 > 2);
                endcase
            end
        end
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_material, m_hit, m_status);
    end

    // run limit
    initial begin
        #1_000_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic beat_t mk(logic [CMD_W-1:0] cmd, int f0, int f1, int f2,
                                 int s0, int s1, int s2, rad_t r, logic leaf);
        beat_t it;
        it.cmd = cmd;
        it.f[0] = coord_t'(f0); it.f[1] = coord_t'(f1); it.f[2] = coord_t'(f2);
        it.s[0] = coord_t'(s0); it.s[1] = coord_t'(s1); it.s[2] = coord_t'(s2);
        it.radius = r;
        it.leaf = leaf;
        return it;
    endfunction

    function automatic coord_t rnd_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return coord_t'(int'($urandom_range(0, 40000)) - 20000);
        if (sel < 95) return coord_t'($urandom);
        if (sel < 97) return COORD_MIN;
        return COORD_MAX;
    endfunction

    function automatic coord_t near(coord_t c, int spread);
        return coord_t'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic rad_t rnd_radius();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 88) return rad_t'($urandom_range(0, 8000));
        if (sel < 97) return rad_t'($urandom);
        return sel[0] ? RAD_MAX : '0;
    endfunction

    // one input beat, with burst gaps in front when enabled
    task automatic send(input beat_t it);
        int gap;
        gap = 0;
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_cmd <= it.cmd;
        s_first_x <= it.f[0]; s_first_y <= it.f[1]; s_first_z <= it.f[2];
        s_second_x <= it.s[0]; s_second_y <= it.s[1]; s_second_z <= it.s[2];
        s_prim_radius <= it.radius;
        s_is_leaf <= it.leaf;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        n_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        while (board.pending_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // all four registers, one per cycle, block idle
    task automatic write_regs(code_t wood, code_t leaf, code_t air, rad_t min_r);
        logic [CFG_DATA_W-1:0] vals[4];
        vals[0] = CFG_DATA_W'(wood);
        vals[1] = CFG_DATA_W'(leaf);
        vals[2] = CFG_DATA_W'(air);
        vals[3] = CFG_DATA_W'(min_r);
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            board.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    // random beats, table kept small so scans stay short
    task automatic random_phase(int n);
        beat_t it;
        prim_t p;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            it = mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, rnd_radius(), $urandom_range(0, 1));
            for (int k = 0; k < 3; k++) begin
                it.f[k] = rnd_coord();
                it.s[k] = rnd_coord();
            end
            if (board.count > 0) p = board.prims[$urandom_range(0, board.count - 1)];
            if (sel < 3 || (sel < 33 && board.count >= 4 && sel[0])) begin
                it.cmd = CMD_CLEAR;
            end else if (sel < 33 || board.count == 0 && sel < 50) begin
                it.cmd = CMD_LOAD;
                if ($urandom_range(0, 3) != 0)
                    for (int k = 0; k < 3; k++)
                        it.s[k] = $urandom_range(0, 4) == 0 ? it.f[k] : near(it.f[k], 15000);
            end else if (sel < 72) begin
                it.cmd = CMD_POINT;
                if (board.count > 0 && $urandom_range(0, 9) < 6) begin
                    it.f[0] = near(sel[1] ? p.ax : p.bx, 3000);
                    it.f[1] = near(sel[1] ? p.ay : p.by, 3000);
                    it.f[2] = near(sel[1] ? p.az : p.bz, 3000);
                end
            end else if (sel < 90 || sel >= 97) begin
                it.cmd = sel >= 97 ? CMD_CONTAIN : CMD_TOUCH;
                if ($urandom_range(0, 9) != 0) begin
                    if (board.count > 0) begin
                        it.f[0] = near(p.ax, 4000);
                        it.f[1] = near(p.ay, 4000);
                        it.f[2] = near(p.az, 4000);
                    end
                    for (int k = 0; k < 3; k++)
                        it.s[k] = coord_t'(int'(it.f[k]) +
                                  int'($urandom_range(0, it.cmd == CMD_TOUCH ? 6000 : 1500)));
                    if ($urandom_range(0, 9) == 0) begin
                        it.s[0] = it.f[0];
                        it.f[0] = coord_t'(int'(near(it.f[0], 1000)) + 1200);
                    end
                end
            end else begin
                it.cmd = CMD_SPARE - CMD_W'($urandom_range(0, CMD_SPARE - CMD_CONTAIN - 1));
            end
            send(it);
            if ($urandom_range(0, 199) == 0) wait_idle();
            if (i % 200 == 100) bursty = ~bursty;
        end
    endtask

    // stimulus
    initial begin
        board = new();
        aresetn <= 0;
        cfg_we <= 0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 0;
        s_cmd <= CMD_CLEAR;
        s_first_x <= '0; s_first_y <= '0; s_first_z <= '0;
        s_second_x <= '0; s_second_y <= '0; s_second_z <= '0;
        s_prim_radius <= '0;
        s_is_leaf <= 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty table, unknown command
        send(mk(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_TOUCH, -1000, -1000, -1000, 1000, 1000, 1000, 0, 0));
        send(mk(CMD_CONTAIN, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_SPARE, 5, 5, 5, 5, 5, 5, RAD_MAX, 1));
        // wood capsule, leaf ball, zero-radius wood at the coordinate extremes
        send(mk(CMD_LOAD, 0, 0, 0, 10240, 0, 0, 2048, 0));
        send(mk(CMD_LOAD, 20480, 0, 0, 20480, 0, 0, 4096, 1));
        send(mk(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                0, 0));
        // inside body, leaf only, air, past end cap, before start cap, extreme corner
        send(mk(CMD_POINT, 5120, 1000, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, 20480, 1024, 3000, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, 0, 50000, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, 11000, 0, 500, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, -1500, 0, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 0));
        // boxes: overlap, inverted, contained, too large
        send(mk(CMD_TOUCH, 11000, 2500, -100, 13000, 4000, 100, 0, 0));
        send(mk(CMD_TOUCH, 3000, 3000, 3000, -3000, -3000, -3000, 0, 0));
        send(mk(CMD_CONTAIN, 2000, -500, -500, 8000, 500, 500, 0, 0));
        send(mk(CMD_CONTAIN, -4000, -4000, -4000, 30000, 4000, 4000, 0, 0));
        send(mk(CMD_TOUCH, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                0, 0));
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_POINT, 5120, 0, 0, 0, 0, 0, 0, 0));
        random_phase(250);

        // long receiver hold-off while beats keep coming
        wait_idle();
        hold_left = 800;
        bursty = 0;
        for (int i = 0; i < 12; i++) send(mk(CMD_SPARE, i, 0, 0, 0, 0, 0, 0, 0));
        bursty = 1;
        wait_idle();

        write_regs(16'hFFFF, 16'h0000, 16'hFFFF, '0);
        random_phase(250);
        wait_idle();
        write_regs(code_t'($urandom), code_t'($urandom), 16'h0000, RAD_MAX);
        random_phase(200);
        wait_idle();
        write_regs(16'h0000, 16'hFFFF, 16'h0001, rad_t'($urandom_range(500, 4000)));
        random_phase(250);

        // fill the table, one load past the end, one scan of the full table
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send(mk(CMD_LOAD, i * 300, -i * 100, 7000, i * 300 + 200, -i * 100, 7000,
                    rad_t'($urandom_range(0, 150)), i[0]));
        send(mk(CMD_POINT, 0, 900000, 0, 0, 0, 0, 0, 0));
        send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        random_phase(100);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("%0d beats sent, %0d results checked; points wood/leaf/air %0d/%0d/%0d",
                 n_sent, board.checked, board.n_wood, board.n_leaf, board.n_air);
        $display("box overlap hits %0d, box contained hits %0d, dropped loads %0d",
                 board.n_touch_hit, board.n_contain_hit, board.n_dropped);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
